[rtl/qcbp_pkg.sv]
// Package for the quantization code bit packer.
// Holds the shared widths, width select codes, word and packing result structs and the width decode.
// No dependencies.
package qcbp_pkg;

    localparam int MAX_CODE_WIDTH = 12;
    localparam int CODE_W         = 12;
    localparam int SEL_W          = 3;
    localparam int RES_W          = 7;
    localparam int RES_CNT_W      = 3;
    localparam int WIDTH_W        = $clog2(MAX_CODE_WIDTH + 1);
    localparam int ACC_W          = CODE_W + RES_W;
    localparam int TOT_W          = $clog2(RES_W + MAX_CODE_WIDTH + 1);

    localparam logic [SEL_W-1:0] SEL_W1    = 3'd0;
    localparam logic [SEL_W-1:0] SEL_W2    = 3'd1;
    localparam logic [SEL_W-1:0] SEL_W3    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_W4    = 3'd3;
    localparam logic [SEL_W-1:0] SEL_W6    = 3'd4;
    localparam logic [SEL_W-1:0] SEL_W8    = 3'd5;
    localparam logic [SEL_W-1:0] SEL_W12   = 3'd6;
    localparam logic [SEL_W-1:0] SEL_RESET = SEL_W8;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
    } t_out_word;

    typedef struct packed {
        logic [1:0]           word_count;
        t_out_word            word0;
        t_out_word            word1;
        logic [RES_W-1:0]     res_bits;
        logic [RES_CNT_W-1:0] res_count;
    } t_pack_res;

    function automatic logic [WIDTH_W-1:0] code_width(input logic [SEL_W-1:0] sel);
        int w;
        case (sel)
            SEL_W1:  w = 1;
            SEL_W2:  w = 2;
            SEL_W3:  w = 3;
            SEL_W4:  w = 4;
            SEL_W6:  w = 6;
            SEL_W8:  w = 8;
            SEL_W12: w = 12;
            default: w = 8;
        endcase
        if (w > MAX_CODE_WIDTH) begin
            w = MAX_CODE_WIDTH;
        end
        return WIDTH_W'(w);
    endfunction

endpackage

[rtl/qcbp_ifs.sv]
// Handshake interfaces of the quantization code bit packer: code input, byte output, config.
// Depends on qcbp_pkg for the field widths.
interface qcbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [qcbp_pkg::CODE_W-1:0]   code_value;
    logic                          last_code;
    modport source (output valid, output code_value, output last_code, input ready);
    modport sink   (input valid, input code_value, input last_code, output ready);
endinterface

interface qcbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       final_byte;
    modport source (output valid, output packed_byte, output final_byte, input ready);
    modport sink   (input valid, input packed_byte, input final_byte, output ready);
endinterface

interface qcbp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [qcbp_pkg::SEL_W-1:0]   width_select;
    modport source (output valid, output width_select, input ready);
    modport sink   (input valid, input width_select, output ready);
endinterface

[rtl/qcbp_pack.sv]
// Combinational packing step: merges one masked code with the leftover bits.
// Produces up to two output words and the next leftover state. Depends on qcbp_pkg.
module qcbp_pack (
    input  logic [qcbp_pkg::SEL_W-1:0]     i_width_sel,
    input  logic [qcbp_pkg::RES_W-1:0]     i_res_bits,
    input  logic [qcbp_pkg::RES_CNT_W-1:0] i_res_count,
    input  logic [qcbp_pkg::CODE_W-1:0]    i_code,
    input  logic                           i_last,
    output qcbp_pkg::t_pack_res            o_res
);

    logic [qcbp_pkg::WIDTH_W-1:0] w;
    logic [qcbp_pkg::CODE_W-1:0]  masked;
    logic [qcbp_pkg::ACC_W-1:0]   acc;
    logic [qcbp_pkg::ACC_W-1:0]   rest;
    logic [qcbp_pkg::TOT_W-1:0]   total;
    logic [qcbp_pkg::TOT_W-1:0]   remain;
    logic [1:0]                   full;
    logic [1:0]                   cnt;
    logic [qcbp_pkg::RES_CNT_W-1:0] keep_cnt;
    logic [qcbp_pkg::RES_W-1:0]   keep_mask;

    always_comb begin
        w = qcbp_pkg::code_width(i_width_sel);
        for (int i = 0; i < qcbp_pkg::CODE_W; i++) begin
            masked[i] = i_code[i] & (i < int'(w));
        end
        acc = qcbp_pkg::ACC_W'(i_res_bits)
            | (qcbp_pkg::ACC_W'(masked) << i_res_count);
        total = qcbp_pkg::TOT_W'(i_res_count) + qcbp_pkg::TOT_W'(w);

        if (total >= qcbp_pkg::TOT_W'(16)) begin
            full   = 2'd2;
            remain = total - qcbp_pkg::TOT_W'(16);
            rest   = acc >> 16;
        end else if (total >= qcbp_pkg::TOT_W'(8)) begin
            full   = 2'd1;
            remain = total - qcbp_pkg::TOT_W'(8);
            rest   = acc >> 8;
        end else begin
            full   = 2'd0;
            remain = total;
            rest   = acc;
        end

        keep_cnt = remain[qcbp_pkg::RES_CNT_W-1:0];
        for (int i = 0; i < qcbp_pkg::RES_W; i++) begin
            keep_mask[i] = (i < int'(keep_cnt));
        end

        if (i_last && (remain != '0) && (full != 2'd2)) begin
            cnt = full + 2'd1;
        end else begin
            cnt = full;
        end

        o_res.word_count          = cnt;
        o_res.word0.packed_byte   = acc[7:0];
        o_res.word0.final_byte    = i_last && (cnt == 2'd1);
        o_res.word1.packed_byte   = acc[15:8];
        o_res.word1.final_byte    = i_last && (cnt == 2'd2);
        if (i_last) begin
            o_res.res_bits  = '0;
            o_res.res_count = '0;
        end else begin
            o_res.res_bits  = rest[qcbp_pkg::RES_W-1:0] & keep_mask;
            o_res.res_count = keep_cnt;
        end
    end

endmodule

[rtl/qcbp_out_fifo.sv]
// Four-entry output word queue taking up to two words per cycle and giving one while o_byte is ready.
// Drives the byte output channel. Depends on qcbp_pkg and qcbp_ifs.
module qcbp_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qcbp_pkg::t_pack_res  i_push,
    input  logic                 i_push_en,
    output logic                 o_space,
    qcbp_out_if.source           o_byte
);

    qcbp_pkg::t_out_word r_mem [0:3];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [1:0] n_wr_ptr;
    logic [1:0] n_rd_ptr;
    logic [2:0] n_count;
    logic [1:0] push_cnt;
    logic       pop;

    always_comb begin
        push_cnt = i_push_en ? i_push.word_count : 2'd0;
        pop      = o_byte.valid && o_byte.ready;
        n_wr_ptr = r_wr_ptr + push_cnt;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, push_cnt} - {2'b00, pop};
    end

    assign o_space            = (r_count <= 3'd2);
    assign o_byte.valid       = (r_count != 3'd0);
    assign o_byte.packed_byte = r_mem[r_rd_ptr].packed_byte;
    assign o_byte.final_byte  = r_mem[r_rd_ptr].final_byte;

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.word0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/quant_code_bit_packer_unit.sv]
// Top level of the quantization code bit packer: input register, packing step, output queue.
// Depends on qcbp_pkg, qcbp_ifs, qcbp_pack and qcbp_out_fifo.
//
//   port      direction  payload                      role
//   i_code    in         code_value[11:0], last_code  one code per word
//   o_byte    out        packed_byte[7:0], final_byte one packed byte per word
//   i_cfg     in         width_select[2:0]            code width, clears leftover bits
//
// A code is registered and, once the output queue has room, packed into zero to two bytes
// that are written to the queue and then seen on o_byte. The queue sends one byte per cycle
// while o_byte is ready, so codes of 8 bits or less go at up to one per cycle, and 12-bit
// codes, which make one and two bytes in turn, go at two codes per three bytes sent.
// A code is taken while the input register is empty or is being packed, and it is packed
// only when the output queue has room for two bytes; stalls on o_byte thus reach i_code.
// Reset is synchronous; it empties the queue and the leftover bits and selects 8-bit codes.
module quant_code_bit_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qcbp_in_if.sink     i_code,
    qcbp_out_if.source  o_byte,
    qcbp_cfg_if.sink    i_cfg
);

    logic                            r_in_valid;
    logic [qcbp_pkg::CODE_W-1:0]     r_code;
    logic                            r_last;
    logic [qcbp_pkg::SEL_W-1:0]      r_width_sel;
    logic [qcbp_pkg::RES_W-1:0]      r_res_bits;
    logic [qcbp_pkg::RES_CNT_W-1:0]  r_res_count;
    qcbp_pkg::t_pack_res             pack_res;
    logic                            space;
    logic                            proc;
    logic                            in_take;

    assign proc           = r_in_valid && space;
    assign i_code.ready   = !r_in_valid || proc;
    assign in_take        = i_code.valid && i_code.ready;
    assign i_cfg.ready    = 1'b1;

    qcbp_pack u_pack (
        .i_width_sel (r_width_sel),
        .i_res_bits  (r_res_bits),
        .i_res_count (r_res_count),
        .i_code      (r_code),
        .i_last      (r_last),
        .o_res       (pack_res)
    );

    qcbp_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (pack_res),
        .i_push_en (proc),
        .o_space   (space),
        .o_byte    (o_byte)
    );

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_code <= i_code.code_value;
            r_last <= i_code.last_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_width_sel <= qcbp_pkg::SEL_RESET;
            r_res_bits  <= '0;
            r_res_count <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_width_sel <= i_cfg.width_select;
                r_res_bits  <= '0;
                r_res_count <= '0;
            end else if (proc) begin
                r_res_bits  <= pack_res.res_bits;
                r_res_count <= pack_res.res_count;
            end
        end
    end

endmodule
